### hw/rtl/ici_pkg.sv
package ici_pkg;

  localparam int COORD_W          = 20;
  localparam int COORD_FRAC_BITS  = 8;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int PAD_CELLS        = 2;
  localparam int EDGE_SLACK       = 1;
  localparam int CONV_SLACK       = 1;

  localparam int CELL_W  = COORD_W - COORD_FRAC_BITS + 2;
  localparam int SADDR_W = 20;
  localparam int WW      = WEIGHT_FRAC_BITS + 4;
  localparam int MW      = WEIGHT_FRAC_BITS + 3;
  localparam int ACCW    = 2 * WW + 12;
  localparam int DIV6_SH = WEIGHT_FRAC_BITS + 4;
  localparam int LIM_SH  = 2 * WEIGHT_FRAC_BITS - 16;

  localparam logic [MW-1:0] ONE_W    = MW'(64'd1 << WEIGHT_FRAC_BITS);
  localparam logic [MW-1:0] DIV6_MUL = MW'(((64'd1 << DIV6_SH) + 64'd5) / 64'd6);
  localparam logic signed [WW-1:0] TWO_THIRDS =
    WW'(((64'd1 << (WEIGHT_FRAC_BITS + 1)) + 64'd1) / 64'd3);

  localparam logic [1:0] KM_NEAREST  = 2'd0;
  localparam logic [1:0] KM_BILINEAR = 2'd1;
  localparam logic [1:0] KM_BSPLINE  = 2'd2;
  localparam logic [1:0] KM_CUBIC    = 2'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [2:0] CFG_KERNEL_MODE  = 3'd0;
  localparam logic [2:0] CFG_WEIGHT_THR   = 3'd1;
  localparam logic [2:0] CFG_ROW_PITCH    = 3'd2;
  localparam logic [2:0] CFG_X_SPAN       = 3'd3;
  localparam logic [2:0] CFG_Y_SPAN       = 3'd4;
  localparam logic [2:0] CFG_PIXEL_REG    = 3'd5;
  localparam logic [2:0] CFG_BAND_COUNT   = 3'd6;
  localparam logic [2:0] CFG_FILL_COLOR   = 3'd7;

  typedef logic signed [WW-1:0] weight_t;

  typedef struct packed {
    logic        action;
    logic [15:0] pixel_addr;
    logic [31:0] pixel_value;
    logic [19:0] query_x;
    logic [19:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] color;
    logic        rejected;
    logic        used_fill;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kernel_mode;
    logic [16:0] weight_threshold;
    logic [12:0] row_pitch;
    logic [19:0] x_span;
    logic [19:0] y_span;
    logic        pixel_registration;
    logic [2:0]  band_count;
    logic [31:0] fill_color;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic               rejected;
    logic [1:0]         kernel_mode;
    logic [SADDR_W-1:0] addr;
    logic [31:0]        pixel_value;
    weight_t [3:0]      wx;
    weight_t [3:0]      wy;
  } job_t;

endpackage

### hw/rtl/ici_front.sv
module ici_front (
  input  logic            clk,
  input  logic            rst_n,
  input  ici_pkg::cfg_t     cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  ici_pkg::in_item_t in_data,
  output logic            push,
  output ici_pkg::job_t     job,
  input  logic            full
);
  import ici_pkg::*;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_SPLIT = 3'd1;
  localparam logic [2:0] F_WGT   = 3'd2;
  localparam logic [2:0] F_ADDR  = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  localparam logic [COORD_W:0] CELL = (COORD_W+1)'(1 << COORD_FRAC_BITS);
  localparam logic [COORD_W:0] HALF = (COORD_W+1)'(1 << (COORD_FRAC_BITS - 1));
  localparam logic [2*MW-1:0] RND_W  = (2*MW)'(64'd1 << (WEIGHT_FRAC_BITS - 1));
  localparam logic [2*MW-1:0] RND_W1 = (2*MW)'(64'd1 << WEIGHT_FRAC_BITS);

  typedef struct packed {
    logic [CELL_W-1:0]           idx;
    logic [WEIGHT_FRAC_BITS-1:0] t;
  } split_t;

  function automatic split_t split_coord(input logic [COORD_W-1:0] q, input logic preg,
                                         input logic [1:0] mode);
    logic [COORD_W:0]             xs;
    logic [CELL_W-1:0]            ip;
    logic [COORD_FRAC_BITS-1:0]   f;
    logic                         up;
    split_t                       s;
    xs = {1'b0, q} + CELL - (preg ? HALF : '0);
    ip = CELL_W'(xs >> COORD_FRAC_BITS);
    f  = xs[COORD_FRAC_BITS-1:0];
    up = ((COORD_W+1)'(f) > HALF) || (((COORD_W+1)'(f) == HALF) && !ip[0]);
    s.t = WEIGHT_FRAC_BITS'({f, {WEIGHT_FRAC_BITS{1'b0}}} >> COORD_FRAC_BITS);
    case (mode)
      KM_NEAREST: begin
        s.idx = ip + CELL_W'(1) + CELL_W'(up);
        s.t   = '0;
      end
      KM_BILINEAR: s.idx = ip + CELL_W'(1);
      default:     s.idx = ip;
    endcase
    return s;
  endfunction

  logic [2:0]                  state_r, state_nxt;
  in_item_t                    item_r;
  logic [1:0]                  mode_r;
  logic                        rej_r;
  logic [WEIGHT_FRAC_BITS-1:0] tx_r, ty_r;
  logic [CELL_W-1:0]           cx_r, cy_r;
  logic [SADDR_W-1:0]          addr_r;
  logic [2:0]                  step_r;
  logic                        axis_r;
  logic [MW-1:0]               p_r, q_r, wp_r;
  weight_t                     w_r [2][4];

  split_t                      sx, sy;
  logic                        rej;
  logic [WEIGHT_FRAC_BITS-1:0] t_cur;
  logic [MW-1:0]               u_cur;
  logic [MW-1:0]               mul_a, mul_b;
  logic [2*MW-1:0]             prod;
  logic [MW-1:0]               rnd_w, rnd_w1;
  weight_t                     t_s, u_s, p_s, wp_s, d6_s, bs_s;
  logic [2:0]                  last_step;

  assign sx  = split_coord(item_r.query_x, cfg.pixel_registration, mode_r);
  assign sy  = split_coord(item_r.query_y, cfg.pixel_registration, mode_r);
  assign rej = ({1'b0, item_r.query_x} > ({1'b0, cfg.x_span} + (COORD_W+1)'(EDGE_SLACK))) ||
               ({1'b0, item_r.query_y} > ({1'b0, cfg.y_span} + (COORD_W+1)'(EDGE_SLACK)));

  assign t_cur = axis_r ? ty_r : tx_r;
  assign u_cur = ONE_W - MW'(t_cur);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    last_step = 3'd0;
    if (mode_r == KM_BSPLINE) begin
      last_step = 3'd5;
      case (step_r)
        3'd0: begin mul_a = MW'(t_cur);     mul_b = MW'(t_cur); end
        3'd1: begin mul_a = p_r;            mul_b = MW'(t_cur); end
        3'd3: begin mul_a = u_cur;          mul_b = u_cur;      end
        3'd4: begin mul_a = p_r;            mul_b = u_cur;      end
        default: begin mul_a = q_r + MW'(3); mul_b = DIV6_MUL; end
      endcase
    end else if (mode_r == KM_CUBIC) begin
      last_step = 3'd3;
      case (step_r)
        3'd0:    begin mul_a = u_cur; mul_b = MW'(t_cur); end
        3'd1:    begin mul_a = wp_r;  mul_b = u_cur;      end
        default: begin mul_a = wp_r;  mul_b = MW'(t_cur); end
      endcase
    end
  end

  assign prod   = mul_a * mul_b;
  assign rnd_w  = MW'((prod + RND_W) >> WEIGHT_FRAC_BITS);
  assign rnd_w1 = MW'((prod + RND_W1) >> (WEIGHT_FRAC_BITS + 1));
  assign t_s    = $signed(WW'(t_cur));
  assign u_s    = $signed(WW'(u_cur));
  assign p_s    = $signed(WW'(p_r));
  assign wp_s   = $signed(WW'(wp_r));
  assign d6_s   = $signed(WW'(prod >> DIV6_SH));
  assign bs_s   = $signed(WW'((q_r + MW'(1)) >> 1)) - p_s + TWO_THIRDS;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_SPLIT;
      F_SPLIT: state_nxt = (item_r.action == ACT_WRITE || rej) ? F_PUSH : F_WGT;
      F_WGT:   if (step_r == last_step && axis_r) state_nxt = F_ADDR;
      F_ADDR:  state_nxt = F_PUSH;
      F_PUSH:  if (!full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      item_r <= in_data;
      mode_r <= cfg.kernel_mode;
    end
    if (state_r == F_SPLIT) begin
      rej_r  <= rej;
      tx_r   <= sx.t;
      ty_r   <= sy.t;
      cx_r   <= sx.idx;
      cy_r   <= sy.idx;
      addr_r <= SADDR_W'(item_r.pixel_addr);
      step_r <= '0;
      axis_r <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 4; k++) begin
          w_r[a][k] <= '0;
        end
      end
    end
    if (state_r == F_WGT) begin
      if (step_r == last_step) begin
        step_r <= '0;
        axis_r <= 1'b1;
      end else begin
        step_r <= step_r + 3'd1;
      end
      case (mode_r)
        KM_NEAREST:  w_r[axis_r][0] <= $signed(WW'(ONE_W));
        KM_BILINEAR: begin
          w_r[axis_r][0] <= u_s;
          w_r[axis_r][1] <= t_s;
        end
        KM_BSPLINE: begin
          case (step_r)
            3'd0, 3'd3: p_r <= rnd_w;
            3'd1, 3'd4: q_r <= rnd_w;
            3'd2: begin
              w_r[axis_r][3] <= d6_s;
              w_r[axis_r][1] <= bs_s;
            end
            default: begin
              w_r[axis_r][0] <= d6_s;
              w_r[axis_r][2] <= bs_s;
            end
          endcase
        end
        default: begin
          case (step_r)
            3'd0: wp_r <= rnd_w;
            3'd1: w_r[axis_r][0] <= -$signed(WW'(rnd_w1));
            3'd2: w_r[axis_r][3] <= -$signed(WW'(rnd_w1));
            default: begin
              w_r[axis_r][1] <= (w_r[axis_r][3] <<< 1) + w_r[axis_r][3] + u_s + wp_s;
              w_r[axis_r][2] <= (w_r[axis_r][0] <<< 1) + w_r[axis_r][0] + t_s + wp_s;
            end
          endcase
        end
      endcase
    end
    if (state_r == F_ADDR) begin
      addr_r <= SADDR_W'(cy_r * cfg.row_pitch) + SADDR_W'(cx_r);
    end
  end

  assign in_stall = (state_r != F_IDLE);
  assign push     = (state_r == F_PUSH) && !full;

  always_comb begin
    job.action      = item_r.action;
    job.rejected    = rej_r;
    job.kernel_mode = mode_r;
    job.addr        = addr_r;
    job.pixel_value = item_r.pixel_value;
    for (int k = 0; k < 4; k++) begin
      job.wx[k] = w_r[0][k];
      job.wy[k] = w_r[1][k];
    end
  end

endmodule

### hw/rtl/ici_fifo.sv
module ici_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ici_pkg::job_t job_in,
  output logic          full,
  input  logic          pop,
  output ici_pkg::job_t job_out,
  output logic          empty
);
  import ici_pkg::*;

  job_t       buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign job_out = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= job_in;
  end

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !empty) else $error("queue lost an item");
  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> !full) else $error("queue did not drain");
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r)) else $error("queue pointers out of step");

endmodule

### hw/rtl/ici_back.sv
module ici_back #(
  parameter int STORE_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ici_pkg::cfg_t      cfg,
  input  logic               empty,
  input  ici_pkg::job_t      job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ici_pkg::out_item_t out_data
);
  import ici_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int DW = ACCW + 9;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_TAP   = 3'd1;
  localparam logic [2:0] B_DRAIN = 3'd2;
  localparam logic [2:0] B_DIV   = 3'd3;
  localparam logic [2:0] B_OUT   = 3'd4;

  logic [31:0]             store_r [STORE_DEPTH];
  logic [31:0]             rd_r, px_r;
  logic [2:0]              state_r, state_nxt;
  weight_t                 wx_r [4];
  weight_t                 wy_r [4];
  logic [1:0]              last_r, ii_r, jj_r, ii1_r, jj1_r;
  logic [AW-1:0]           row_base_r;
  logic                    v1_r, v2_r;
  logic signed [2*WW-1:0]  tw_r;
  logic signed [ACCW-1:0]  acc_r [4];
  logic signed [ACCW-1:0]  wsum_r;
  logic [DW-1:0]           rem_r [4];
  logic [DW-1:0]           den_r;
  logic [7:0]              quo_r [4];
  logic [3:0]              zero_r, sat_r;
  logic                    fill_r;
  logic [2:0]              cnt_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic                    free;
  logic                    mem_we;
  logic [AW-1:0]           mem_addr;
  logic                    tap_done;
  logic signed [ACCW-1:0]  lim;
  logic                    pass;
  logic [3:0]              en;
  logic [31:0]             color;

  assign free     = !out_valid_r || !out_stall;
  assign tap_done = (ii_r == last_r) && (jj_r == last_r);
  assign mem_we   = (state_r == B_IDLE) && !empty && (job.action == ACT_WRITE);
  assign mem_addr = (state_r == B_IDLE) ? job.addr[AW-1:0] : row_base_r + AW'(ii_r);

  always_comb begin
    pop = 1'b0;
    if (state_r == B_IDLE && !empty) begin
      if (job.action == ACT_WRITE) pop = 1'b1;
      else if (job.rejected) pop = free;
      else pop = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (pop && job.action == ACT_QUERY && !job.rejected) state_nxt = B_TAP;
      B_TAP:   if (tap_done) state_nxt = B_DRAIN;
      B_DRAIN: if (!v1_r && !v2_r) state_nxt = B_DIV;
      B_DIV:   if (cnt_r == 3'd7) state_nxt = B_OUT;
      B_OUT:   if (free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_r[mem_addr] <= job.pixel_value;
    rd_r <= store_r[mem_addr];
  end

  assign lim  = ($signed(ACCW'(cfg.weight_threshold)) - ACCW'(CONV_SLACK)) <<< LIM_SH;
  assign pass = (wsum_r > lim) && (wsum_r > 0);
  assign en   = {cfg.band_count >= 3'd4, cfg.band_count >= 3'd3, cfg.band_count >= 3'd2, 1'b1};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      if (!en[b]) color[8*b +: 8] = 8'd0;
      else if (fill_r) color[8*b +: 8] = cfg.fill_color[8*b +: 8];
      else if (zero_r[b]) color[8*b +: 8] = 8'd0;
      else if (sat_r[b]) color[8*b +: 8] = 8'hFF;
      else color[8*b +: 8] = quo_r[b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == B_TAP);
      v2_r    <= v1_r;
      if ((state_r == B_IDLE && pop && job.action == ACT_QUERY && job.rejected) ||
          (state_r == B_OUT && free)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && pop && job.action == ACT_QUERY) begin
      if (job.rejected) begin
        out_data_r.color     <= '0;
        out_data_r.rejected  <= 1'b1;
        out_data_r.used_fill <= 1'b0;
      end else begin
        for (int k = 0; k < 4; k++) begin
          wx_r[k]  <= job.wx[k];
          wy_r[k]  <= job.wy[k];
          acc_r[k] <= '0;
        end
        wsum_r     <= '0;
        row_base_r <= job.addr[AW-1:0];
        ii_r       <= '0;
        jj_r       <= '0;
        case (job.kernel_mode)
          KM_NEAREST:  last_r <= 2'd0;
          KM_BILINEAR: last_r <= 2'd1;
          default:     last_r <= 2'd3;
        endcase
      end
    end
    if (state_r == B_TAP) begin
      ii1_r <= ii_r;
      jj1_r <= jj_r;
      if (ii_r == last_r) begin
        ii_r       <= '0;
        jj_r       <= jj_r + 2'd1;
        row_base_r <= row_base_r + AW'(cfg.row_pitch);
      end else begin
        ii_r <= ii_r + 2'd1;
      end
    end
    if (v1_r) begin
      px_r <= rd_r;
      tw_r <= wx_r[ii1_r] * wy_r[jj1_r];
    end
    if (v2_r) begin
      wsum_r <= wsum_r + ACCW'(tw_r);
      for (int b = 0; b < 4; b++) begin
        acc_r[b] <= acc_r[b] + ACCW'($signed({1'b0, px_r[8*b +: 8]})) * ACCW'(tw_r);
      end
    end
    if (state_r == B_DRAIN && !v1_r && !v2_r) begin
      fill_r <= !pass;
      cnt_r  <= '0;
      den_r  <= DW'(wsum_r) << 8;
      for (int b = 0; b < 4; b++) begin
        zero_r[b] <= (acc_r[b] <= 0);
        sat_r[b]  <= (acc_r[b] >= ((wsum_r <<< 8) - wsum_r));
        rem_r[b]  <= DW'((acc_r[b] <<< 1) + wsum_r);
        quo_r[b]  <= '0;
      end
    end
    if (state_r == B_DIV) begin
      cnt_r <= cnt_r + 3'd1;
      den_r <= den_r >> 1;
      for (int b = 0; b < 4; b++) begin
        if (rem_r[b] >= den_r) begin
          rem_r[b] <= rem_r[b] - den_r;
          quo_r[b] <= {quo_r[b][6:0], 1'b1};
        end else begin
          quo_r[b] <= {quo_r[b][6:0], 1'b0};
        end
      end
    end
    if (state_r == B_OUT && free) begin
      out_data_r.color     <= color;
      out_data_r.rejected  <= 1'b0;
      out_data_r.used_fill <= fill_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_TAP) |-> (jj_r <= last_r && ii_r <= last_r))
    else $error("tap index beyond kernel");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.rejected && out_data_r.used_fill))
    else $error("rejected and fill both set");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |-> !pop) else $error("queue popped while busy");

endmodule

### hw/rtl/image_convolution_interpolate.sv
// convolution image interpolator
// in_* channel: items with action 0 write pixel_value (four bands) to store
// address pixel_addr; action 1 queries point (query_x, query_y), 8 fraction bits.
// out_* channel: one item per query (color, rejected, used_fill), none per write.
// cfg_* channel: register writes by index, always ready; write only while idle.
// a front end splits the coordinate and builds the kernel weights with one
// shared multiplier, stepping through the products for each axis in turn,
// then hands the item to a two-entry queue.
// the back end reads one tap per cycle from the single-port pixel store:
// 1, 4 or 16 taps, then it drains the accumulator pipeline and runs an 8-bit
// divider per band before the result goes out; a write is stored as it is popped.
// a point out of span skips the weights and taps and gives a rejected result.
// reset returns registers to defaults and empties the queue; the pixel store is
// not cleared. a stalled result holds in the output register; the back end
// waits for it, the queue fills, and the input then stalls.
module image_convolution_interpolate #(
  parameter int STORE_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ici_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ici_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ici_pkg::*;

  cfg_t cfg_r;
  logic push, full, pop, empty;
  job_t job_in, job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kernel_mode        <= KM_CUBIC;
      cfg_r.weight_threshold   <= 17'd32768;
      cfg_r.row_pitch          <= 13'd260;
      cfg_r.x_span             <= 20'd65280;
      cfg_r.y_span             <= 20'd65280;
      cfg_r.pixel_registration <= 1'b0;
      cfg_r.band_count         <= 3'd3;
      cfg_r.fill_color         <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KERNEL_MODE: cfg_r.kernel_mode        <= cfg_data[1:0];
        CFG_WEIGHT_THR:  cfg_r.weight_threshold   <= cfg_data[16:0];
        CFG_ROW_PITCH:   cfg_r.row_pitch          <= cfg_data[12:0];
        CFG_X_SPAN:      cfg_r.x_span             <= cfg_data[19:0];
        CFG_Y_SPAN:      cfg_r.y_span             <= cfg_data[19:0];
        CFG_PIXEL_REG:   cfg_r.pixel_registration <= cfg_data[0];
        CFG_BAND_COUNT:  cfg_r.band_count         <= cfg_data[2:0];
        CFG_FILL_COLOR:  cfg_r.fill_color         <= cfg_data;
        default:         cfg_r.fill_color         <= cfg_r.fill_color;
      endcase
    end
  end

  ici_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .job      (job_in),
    .full     (full)
  );

  ici_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (job_in),
    .full    (full),
    .pop     (pop),
    .job_out (job_out),
    .empty   (empty)
  );

  ici_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .empty     (empty),
    .job       (job_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
